// File: rtl/swgcl_pkg.sv
// Shared types, constants and helper functions for the stereo width / gain /
// compressor / limiter block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swgcl_pkg;

	localparam int SMP_W    = 24;
	localparam int LOG_FRAC = 16;
	localparam int EXP_STEPS = 16;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [65:0]      wide_t;
	typedef logic signed [32:0]      mop_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_WIDTH   = 3'd1,
		REG_LEVEL   = 3'd2,
		REG_MAKEUP  = 3'd3,
		REG_THR     = 3'd4,
		REG_SLOPE   = 3'd5,
		REG_ENV     = 3'd6,
		REG_LIMMIX  = 3'd7
	} reg_idx_t;

	// Mode flag bit positions
	localparam int MODE_BYPASS = 0;
	localparam int MODE_WIDTH  = 1;
	localparam int MODE_LEVEL  = 2;
	localparam int MODE_COMP   = 3;
	localparam int MODE_LIMIT  = 4;

	localparam logic [23:0] ENV_FLOOR = 24'd83;
	localparam logic [16:0] MIX_UNITY = 17'd65536;
	localparam logic [16:0] GAIN_ONE  = 17'd65536;
	localparam logic [31:0] P_ONE     = 32'd1 << 30;

	// Round half up: v / 2^s
	function automatic wide_t rnd(input wide_t v, input int s);
		wide_t t;
		t = v + (wide_t'(1) <<< (s - 1));
		return t >>> s;
	endfunction

	// Clamp to the signed sample range
	function automatic smp_t sat(input wide_t v);
		smp_t r;
		if (v > wide_t'(8388607))
			r = 24'sh7FFFFF;
		else if (v < -wide_t'(8388608))
			r = 24'sh800000;
		else
			r = v[SMP_W-1:0];
		return r;
	endfunction

	// Bitwise integer square root, used at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] xx;
		r  = '0;
		b  = 64'd1 << 62;
		xx = x;
		for (int k = 0; k < 32; k++) begin
			if (xx >= r + b) begin
				xx = xx - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Table of 2^(2^-i) in Q1.30, entry i-1 holds c_i
	function automatic logic [EXP_STEPS*32-1:0] exp_coef_table();
		logic [63:0] c;
		logic [EXP_STEPS*32-1:0] t;
		c = 64'd1 << 31;
		t = '0;
		for (int i = 1; i <= EXP_STEPS; i++) begin
			c = isqrt64(c << 30);
			t[32*(i-1) +: 32] = c[31:0];
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// File: rtl/swgcl_div.sv
// Bit-serial restoring divider: quotient = (2^46 + divisor/2) / divisor.
// One quotient bit per cycle, 17 quotient bits. Uses nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module swgcl_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [16:0]      quotient
);

	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [16:0] num_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [46:0] numer;
	logic [31:0] trial;
	logic        qbit;

	assign numer = (47'd1 << 46) + 47'(divisor >> 1);
	assign trial = {rem_q[30:0], num_q[16]};
	assign qbit  = (trial >= div_q);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'(numer[46:17]);
			num_q <= numer[16:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? (trial - div_q) : trial;
			num_q <= {num_q[15:0], 1'b0};
			quo_q <= {quo_q[15:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: rtl/stereo_width_gain_compressor_limiter_top.sv
// Top level of the stereo width / gain / compressor / limiter block.
// Depends on swgcl_pkg and swgcl_div.
//
//  channel | dir | signals                          | transfer when
//  s_      | in  | s_tvalid s_tready s_tdata[47:0]  | s_tvalid & s_tready
//  m_      | out | m_tvalid m_tready m_tdata[47:0]  | m_tvalid & m_tready
//  cfg_    | in  | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid & cfg_ready
//
// One frame at a time through a sequencer around one shared 33x33 multiplier.
// Bypass goes straight to the output. With gain reduction, frame time is set
// by two 16-step log2 squaring passes, the 16-step exp2 product and the
// 17-step divider. s_tready is high only while the sequencer is idle; a
// finished frame waits in the output register without blocking the next input.
// Reset clears control state and loads the register defaults; envelope is zero.
`timescale 1ns / 1ps
`default_nettype none
module stereo_width_gain_compressor_limiter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // left_sample[23:0], right_sample[47:24]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // left_out[23:0], right_out[47:24]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [40:0] cfg_data
);

	localparam logic [swgcl_pkg::EXP_STEPS*32-1:0] C_TAB = swgcl_pkg::exp_coef_table();

	typedef enum logic [4:0] {
		S_IDLE, S_WID_M, S_WID_A, S_LVL_L, S_LVL_R, S_LVL_W, S_ENV_M, S_ENV_W,
		S_CHK, S_LOGE, S_LOGT, S_KMUL, S_KW, S_EXP, S_DIV, S_DIVW,
		S_CA_L1, S_CA_L2, S_CA_R1, S_CA_R2, S_CA_W, S_LIM, S_MIX_L, S_MIX_R,
		S_MIX_W, S_OUT
	} state_t;

	// Configuration registers
	logic [4:0]  mode_q;
	logic [15:0] width_gain_q;
	logic [15:0] level_gain_q;
	logic [15:0] makeup_gain_q;
	logic [22:0] thr_q;
	logic [15:0] slope_q;
	logic [31:0] coeffs_q;
	logic [40:0] limmix_q;

	// Sequencer and datapath registers
	state_t                 state_q;
	swgcl_pkg::smp_t        dl_q, dr_q, sl_q, sr_q;
	logic [23:0]            env_q;
	logic [23:0]            e_q;
	logic [31:0]            m_q;
	logic [20:0]            lres_q;
	logic [20:0]            loge_q;
	logic [21:0]            d_q;
	logic [3:0]             cnt_q;
	logic [15:0]            f_q;
	logic [4:0]             n_q;
	logic [31:0]            p_q;
	logic [16:0]            gain_q;
	swgcl_pkg::wide_t       prod_q;
	logic                   out_valid_q;
	swgcl_pkg::smp_t        out_l_q, out_r_q;

	// Combinational
	swgcl_pkg::mop_t        op_a, op_b;
	swgcl_pkg::wide_t       mul_w;
	logic [23:0]            abs_l, abs_r, e_w;
	logic [15:0]            coef_w;
	logic [31:0]            sq_w;
	logic [31:0]            m_next;
	logic [20:0]            lres_next;
	logic [4:0]             tb_env, tb_thr;
	logic [23:0]            thr_x;
	logic [23:0]            lim_w;
	logic [16:0]            mix_w;
	logic [36:0]            k_w;
	logic                   div_start, div_busy, div_done;
	logic [16:0]            div_q;
	state_t                 st_cmp, st_lim, st_mix, st_lvl, st_wid;
	swgcl_pkg::wide_t       mid_w, lim_s;
	swgcl_pkg::smp_t        lim_l, lim_r;
	logic [31:0]            cval;

	// Index of the highest set bit
	function automatic logic [4:0] top_bit(input logic [23:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 24; i++) begin
			if (x[i])
				p = 5'(i);
		end
		return p;
	endfunction

	function automatic logic [23:0] mag(input swgcl_pkg::smp_t v);
		logic [24:0] t;
		t = v[23] ? (25'd0 - 25'(v)) : 25'(v);
		return t[23:0];
	endfunction

	// Configuration write channel, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 5'd0;
			width_gain_q  <= 16'd16384;
			level_gain_q  <= 16'd4096;
			makeup_gain_q <= 16'd4096;
			thr_q         <= 23'd8388607;
			slope_q       <= 16'd0;
			coeffs_q      <= 32'd4277141490;
			limmix_q      <= 41'd1044536033280;
		end else if (cfg_valid) begin
			case (swgcl_pkg::reg_idx_t'(cfg_index))
				swgcl_pkg::REG_MODE:   mode_q        <= cfg_data[4:0];
				swgcl_pkg::REG_WIDTH:  width_gain_q  <= cfg_data[15:0];
				swgcl_pkg::REG_LEVEL:  level_gain_q  <= cfg_data[15:0];
				swgcl_pkg::REG_MAKEUP: makeup_gain_q <= cfg_data[15:0];
				swgcl_pkg::REG_THR:    thr_q         <= cfg_data[22:0];
				swgcl_pkg::REG_SLOPE:  slope_q       <= cfg_data[15:0];
				swgcl_pkg::REG_ENV:    coeffs_q      <= cfg_data[31:0];
				swgcl_pkg::REG_LIMMIX: limmix_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage order: width, level, compressor, limiter, mix
	assign lim_w  = limmix_q[40:17];
	assign mix_w  = limmix_q[16:0];
	assign st_mix = (mix_w < swgcl_pkg::MIX_UNITY) ? S_MIX_L : S_OUT;
	assign st_lim = mode_q[swgcl_pkg::MODE_LIMIT] ? S_LIM : st_mix;
	assign st_cmp = mode_q[swgcl_pkg::MODE_COMP] ? S_ENV_M : st_lim;
	assign st_lvl = mode_q[swgcl_pkg::MODE_LEVEL] ? S_LVL_L : st_cmp;
	assign st_wid = mode_q[swgcl_pkg::MODE_WIDTH] ? S_WID_M : st_lvl;

	// Envelope detector inputs
	assign abs_l  = mag(sl_q);
	assign abs_r  = mag(sr_q);
	assign e_w    = (abs_l > abs_r) ? abs_l : abs_r;
	assign coef_w = (e_w > env_q) ? coeffs_q[31:16] : coeffs_q[15:0];

	// Log2 squaring step
	assign sq_w      = mul_w[61:30];
	assign m_next    = sq_w[31] ? (sq_w >> 1) : sq_w;
	assign lres_next = lres_q | (sq_w[31] ? (21'd1 << (4'd15 - cnt_q)) : 21'd0);
	assign thr_x     = (thr_q == 23'd0) ? 24'd1 : {1'b0, thr_q};
	assign tb_env    = top_bit(env_q);
	assign tb_thr    = top_bit(thr_x);
	assign k_w       = prod_q[52:16];
	assign cval      = C_TAB[32*cnt_q +: 32];
	assign mid_w     = (swgcl_pkg::wide_t'(dl_q) + swgcl_pkg::wide_t'(dr_q)) <<< 14;

	// Shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_WID_M: begin
				op_a = 33'(dl_q) - 33'(dr_q);
				op_b = 33'($signed({1'b0, width_gain_q}));
			end
			S_LVL_L: begin
				op_a = 33'(sl_q);
				op_b = 33'($signed({1'b0, level_gain_q}));
			end
			S_LVL_R: begin
				op_a = 33'(sr_q);
				op_b = 33'($signed({1'b0, level_gain_q}));
			end
			S_ENV_M: begin
				op_a = 33'($signed({1'b0, env_q})) - 33'($signed({1'b0, e_w}));
				op_b = 33'($signed({1'b0, coef_w}));
			end
			S_LOGE, S_LOGT: begin
				op_a = $signed({1'b0, m_q});
				op_b = $signed({1'b0, m_q});
			end
			S_KMUL: begin
				op_a = 33'($signed({1'b0, d_q}));
				op_b = 33'($signed({1'b0, slope_q}));
			end
			S_EXP: begin
				op_a = $signed({1'b0, p_q});
				op_b = $signed({1'b0, cval});
			end
			S_CA_L1: begin
				op_a = 33'(sl_q);
				op_b = 33'($signed({1'b0, gain_q}));
			end
			S_CA_R1: begin
				op_a = 33'(sr_q);
				op_b = 33'($signed({1'b0, gain_q}));
			end
			S_CA_L2, S_CA_R2: begin
				op_a = 33'(swgcl_pkg::rnd(prod_q, 16));
				op_b = 33'($signed({1'b0, makeup_gain_q}));
			end
			S_MIX_L: begin
				op_a = 33'(sl_q) - 33'(dl_q);
				op_b = 33'($signed({1'b0, mix_w}));
			end
			S_MIX_R: begin
				op_a = 33'(sr_q) - 33'(dr_q);
				op_b = 33'($signed({1'b0, mix_w}));
			end
			default: ;
		endcase
	end

	assign mul_w = op_a * op_b;

	// Symmetric clip
	assign lim_s = swgcl_pkg::wide_t'($signed({1'b0, lim_w}));
	always_comb begin
		lim_l = sl_q;
		lim_r = sr_q;
		if (swgcl_pkg::wide_t'(sl_q) > lim_s)
			lim_l = lim_s[23:0];
		else if (swgcl_pkg::wide_t'(sl_q) < -lim_s)
			lim_l = 24'(-lim_s);
		if (swgcl_pkg::wide_t'(sr_q) > lim_s)
			lim_r = lim_s[23:0];
		else if (swgcl_pkg::wide_t'(sr_q) < -lim_s)
			lim_r = 24'(-lim_s);
	end

	assign div_start = (state_q == S_DIV);

	swgcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (p_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// Product register: one multiply per cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_w;
	end

	// Sequencer with state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			env_q       <= '0;
			cnt_q       <= '0;
		end else begin
			// Drop the output once taken, unless a new frame is handed over
			if (m_tready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						dl_q <= s_tdata[23:0];
						dr_q <= s_tdata[47:24];
						sl_q <= s_tdata[23:0];
						sr_q <= s_tdata[47:24];
						state_q <= mode_q[swgcl_pkg::MODE_BYPASS] ? S_OUT : st_wid;
					end
				end
				S_WID_M: state_q <= S_WID_A;
				S_WID_A: begin
					sl_q <= swgcl_pkg::sat(swgcl_pkg::rnd(mid_w + prod_q, 15));
					sr_q <= swgcl_pkg::sat(swgcl_pkg::rnd(mid_w - prod_q, 15));
					state_q <= st_lvl;
				end
				S_LVL_L: state_q <= S_LVL_R;
				S_LVL_R: begin
					sl_q <= swgcl_pkg::sat(swgcl_pkg::rnd(prod_q, 12));
					state_q <= S_LVL_W;
				end
				S_LVL_W: begin
					sr_q <= swgcl_pkg::sat(swgcl_pkg::rnd(prod_q, 12));
					state_q <= st_cmp;
				end
				S_ENV_M: begin
					e_q <= e_w;
					state_q <= S_ENV_W;
				end
				S_ENV_W: begin
					env_q <= 24'(swgcl_pkg::wide_t'($signed({1'b0, e_q}))
						+ swgcl_pkg::rnd(prod_q, 16));
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (env_q > {1'b0, thr_q} && env_q > swgcl_pkg::ENV_FLOOR) begin
						m_q    <= 32'(env_q) << (5'd30 - tb_env);
						lres_q <= 21'(tb_env) << swgcl_pkg::LOG_FRAC;
						cnt_q  <= '0;
						state_q <= S_LOGE;
					end else begin
						gain_q  <= swgcl_pkg::GAIN_ONE;
						state_q <= S_CA_L1;
					end
				end
				S_LOGE: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						loge_q <= lres_next;
						m_q    <= 32'(thr_x) << (5'd30 - tb_thr);
						lres_q <= 21'(tb_thr) << swgcl_pkg::LOG_FRAC;
						state_q <= S_LOGT;
					end else begin
						m_q    <= m_next;
						lres_q <= lres_next;
					end
				end
				S_LOGT: begin
					cnt_q  <= cnt_q + 4'd1;
					m_q    <= m_next;
					lres_q <= lres_next;
					if (cnt_q == 4'd15) begin
						d_q <= (loge_q > lres_next) ? 22'(loge_q - lres_next) : 22'd0;
						state_q <= S_KMUL;
					end
				end
				S_KMUL: state_q <= S_KW;
				S_KW: begin
					if (k_w[36:16] >= 21'd17) begin
						gain_q  <= '0;
						state_q <= S_CA_L1;
					end else begin
						n_q   <= k_w[20:16];
						f_q   <= k_w[15:0];
						p_q   <= swgcl_pkg::P_ONE;
						cnt_q <= '0;
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					cnt_q <= cnt_q + 4'd1;
					if (f_q[4'd15 - cnt_q])
						p_q <= mul_w[61:30];
					if (cnt_q == 4'd15)
						state_q <= S_DIV;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						gain_q  <= div_q >> n_q;
						state_q <= S_CA_L1;
					end
				end
				S_CA_L1: state_q <= S_CA_L2;
				S_CA_L2: state_q <= S_CA_R1;
				S_CA_R1: begin
					sl_q <= swgcl_pkg::sat(swgcl_pkg::rnd(prod_q, 12));
					state_q <= S_CA_R2;
				end
				S_CA_R2: state_q <= S_CA_W;
				S_CA_W: begin
					sr_q <= swgcl_pkg::sat(swgcl_pkg::rnd(prod_q, 12));
					state_q <= st_lim;
				end
				S_LIM: begin
					sl_q <= lim_l;
					sr_q <= lim_r;
					state_q <= st_mix;
				end
				S_MIX_L: state_q <= S_MIX_R;
				S_MIX_R: begin
					sl_q <= swgcl_pkg::sat(swgcl_pkg::wide_t'(dl_q)
						+ swgcl_pkg::rnd(prod_q, 16));
					state_q <= S_MIX_W;
				end
				S_MIX_W: begin
					sr_q <= swgcl_pkg::sat(swgcl_pkg::wide_t'(dr_q)
						+ swgcl_pkg::rnd(prod_q, 16));
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hand over once the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_l_q     <= sl_q;
						out_r_q     <= sr_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_r_q, out_l_q};

	// Envelope moves only in its update step
	a_env_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ENV_W) |=> $stable(env_q))
		else $error("envelope changed outside its update step");

	// Divider is never restarted while running
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// Compressor gain never exceeds unity
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CA_L1) |-> (gain_q <= swgcl_pkg::GAIN_ONE))
		else $error("compressor gain above unity");

endmodule
`default_nettype wire
